// ===== hdl/fse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_pkg: shared types and constants of the format string expander
// Character codes, digit unit constants and the digit unit result word.
// ----------------------------------------------------------------------------
package fse_pkg;

    // Width of the argument field on the input channel
    localparam int ARG_W         = 32;
    localparam int ARG_WIDTH_DEF = 32;

    // Digit store depth and the width of its counter
    localparam int DIGIT_SLOTS = 10;
    localparam int CNT_W       = 4;
    localparam int DIG_W       = 4;

    // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP) >> RECIP_SHIFT
    localparam logic [ARG_W-1:0] RECIP       = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;
    localparam int               HEX_SHIFT   = 4;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_DU    = 8'h44;
    localparam logic [7:0] CH_IU    = 8'h49;
    localparam logic [7:0] CH_XU    = 8'h58;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_X     = 8'h78;

    // One step of the digit unit: next quotient and the digit peeled off
    typedef struct packed {
        logic [ARG_W-1:0] quot;
        logic [DIG_W-1:0] digit;
    } t_div_res;

    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
        logic [7:0] dx;
        dx = {{(8-DIG_W){1'b0}}, d};
        if (d < DIG_W'(10)) begin
            return CH_0 + dx;
        end
        return CH_A + dx - 8'd10;
    endfunction

endpackage

// ===== hdl/fse_digit_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fse_digit_unit: shared divide-by-radix unit
// Peels one digit off a magnitude: radix 16 by shift, radix 10 by a
// registered reciprocal multiply followed by a narrow remainder correction.
// ----------------------------------------------------------------------------
module fse_digit_unit
    import fse_pkg::*;
(
    input  logic             i_clk,
    input  logic [ARG_W-1:0] i_mag,
    input  logic             i_hex,
    output t_div_res         o_res
);

    logic [2*ARG_W-1:0] r_prod;
    logic [ARG_W-1:0]   w_q_dec;
    logic [DIG_W-1:0]   w_q10_low;

    // Product is valid the cycle after the magnitude settles
    always_ff @(posedge i_clk) begin
        r_prod <= (2*ARG_W)'(i_mag) * (2*ARG_W)'(RECIP);
    end

    assign w_q_dec   = ARG_W'(r_prod[2*ARG_W-1:RECIP_SHIFT]);
    // Low bits of q * 10 = (q << 3) + (q << 1); the remainder stays below ten
    assign w_q10_low = {w_q_dec[0], 3'b000} + {w_q_dec[2:0], 1'b0};

    always_comb begin
        if (i_hex) begin
            o_res.quot  = i_mag >> HEX_SHIFT;
            o_res.digit = i_mag[DIG_W-1:0];
        end else begin
            o_res.quot  = w_q_dec;
            o_res.digit = i_mag[DIG_W-1:0] - w_q10_low;
        end
    end

endmodule

// ===== hdl/format_string_expander_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_string_expander_top: minimal printf-style formatter
// Takes one format byte with an argument word per input word and emits the
// resulting text bytes, flagging the last byte caused by each input word.
// ----------------------------------------------------------------------------
// Literal bytes, the terminating zero and "%%" are presented on the output
// the cycle after they are accepted; a '%' in literal mode emits nothing. A
// decimal conversion is accepted (emitting '-' when negative), then peels
// each digit off in the shared digit unit (reciprocal multiply, then
// correction) and then emits the digits, up to ten of them. A hex conversion
// emits "0x", extracts each digit by shift and then emits the digits. The
// input is stalled while a conversion runs and whenever the output register
// is full and stalled; output stalls hold the sequencer in its emitting
// steps.
// ----------------------------------------------------------------------------
module format_string_expander_top
    import fse_pkg::*;
#(
    parameter int ARG_WIDTH = ARG_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_format_char,
    input  logic [ARG_W-1:0] i_arg_value,
    // output channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_char,
    output logic             o_last_of_run
);

    // Only the low bits of the field carry the argument; beyond the field
    // width the argument is zero-extended and never negative.
    localparam int          EFF_W     = (ARG_WIDTH < ARG_W) ? ARG_WIDTH : ARG_W;
    localparam bit          SIGNED_OK = (ARG_WIDTH <= ARG_W);
    localparam logic [63:0] MASK64    = (64'd1 << EFF_W) - 64'd1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PFX  = 5'b00010,
        S_MUL  = 5'b00100,
        S_REM  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        K_NUL,
        K_PCT,
        K_DEC,
        K_HEX,
        K_OTHER
    } t_kind;

    t_state             r_state, n_state;
    logic               r_escape, n_escape;
    logic               r_hex, n_hex;
    logic [ARG_W-1:0]   r_mag, n_mag;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [DIG_W-1:0]   r_digits [0:DIGIT_SLOTS-1];
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_char, n_out_char;
    logic               r_out_last, n_out_last;

    t_kind              w_kind;
    t_div_res           w_div;
    logic [ARG_W-1:0]   w_mask;
    logic [ARG_W-1:0]   w_raw;
    logic [ARG_W-1:0]   w_neg_mag;
    logic               w_neg;
    logic               w_out_free;
    logic               w_in_acc;
    logic [CNT_W-1:0]   w_rd_idx;

    // ---- argument conditioning ----
    assign w_mask    = MASK64[ARG_W-1:0];
    assign w_raw     = i_arg_value & w_mask;
    assign w_neg     = SIGNED_OK && w_raw[EFF_W-1];
    assign w_neg_mag = (ARG_W'(0) - w_raw) & w_mask;

    // ---- handshakes ----
    // The output register is free when empty or being taken this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_last_of_run = r_out_last;

    // Emit digits most significant first: the top written slot.
    assign w_rd_idx = r_count - CNT_W'(1);

    // ---- format byte decode ----
    always_comb begin
        unique case (i_format_char) inside
            CH_NUL:                  w_kind = K_NUL;
            CH_PCT:                  w_kind = K_PCT;
            CH_D, CH_DU, CH_I, CH_IU: w_kind = K_DEC;
            CH_X, CH_XU:             w_kind = K_HEX;
            default:                 w_kind = K_OTHER;
        endcase
    end

    // ---- shared digit unit ----
    fse_digit_unit u_digit (
        .i_clk (i_clk),
        .i_mag (r_mag),
        .i_hex (r_hex),
        .o_res (w_div)
    );

    // ---- sequencer ----
    always_comb begin
        n_state     = r_state;
        n_escape    = r_escape;
        n_hex       = r_hex;
        n_mag       = r_mag;
        n_count     = r_count;
        // drop the held word once it has been taken
        n_out_valid = r_out_valid && i_out_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_kind == K_NUL) begin
                        // terminating zero, whatever the mode
                        n_out_valid = 1'b1;
                        n_out_char  = CH_NUL;
                        n_out_last  = 1'b1;
                        n_escape    = 1'b0;
                    end else if (!r_escape) begin
                        if (w_kind == K_PCT) begin
                            n_escape = 1'b1;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_char  = i_format_char;
                            n_out_last  = 1'b1;
                        end
                    end else begin
                        n_escape = 1'b0;
                        case (w_kind)
                            K_PCT: begin
                                n_out_valid = 1'b1;
                                n_out_char  = CH_PCT;
                                n_out_last  = 1'b1;
                            end
                            K_DEC: begin
                                n_hex   = 1'b0;
                                n_count = '0;
                                n_mag   = w_neg ? w_neg_mag : w_raw;
                                n_state = S_MUL;
                                if (w_neg) begin
                                    n_out_valid = 1'b1;
                                    n_out_char  = CH_MINUS;
                                    n_out_last  = 1'b0;
                                end
                            end
                            K_HEX: begin
                                n_hex       = 1'b1;
                                n_count     = '0;
                                n_mag       = w_raw;
                                n_state     = S_PFX;
                                n_out_valid = 1'b1;
                                n_out_char  = CH_0;
                                n_out_last  = 1'b0;
                            end
                            default: begin
                                // unknown escape: emit nothing
                            end
                        endcase
                    end
                end
            end
            S_PFX: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_X;
                    n_out_last  = 1'b0;
                    n_state     = S_REM;
                end
            end
            S_MUL: begin
                // wait for the reciprocal product
                n_state = S_REM;
            end
            S_REM: begin
                n_mag   = w_div.quot;
                n_count = r_count + CNT_W'(1);
                if ((w_div.quot == '0) || (r_count == CNT_W'(DIGIT_SLOTS - 1))) begin
                    n_state = S_EMIT;
                end else if (r_hex) begin
                    n_state = S_REM;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_char(r_digits[w_rd_idx]);
                    n_out_last  = (r_count == CNT_W'(1));
                    n_count     = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_escape    <= 1'b0;
            r_hex       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_escape    <= n_escape;
            r_hex       <= n_hex;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // Digit store, least significant digit first
    always_ff @(posedge i_clk) begin
        if (r_state == S_REM) begin
            r_digits[r_count] <= w_div.digit;
        end
    end

`ifndef SYNTHESIS
    // Emission only runs over written slots
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_count != '0) && (r_count <= CNT_W'(DIGIT_SLOTS)))
        else $error("digit emission with an empty or overfull store");

    // The reciprocal correction must yield a decimal digit
    a_dec_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_REM) && !r_hex) |-> (w_div.digit < DIG_W'(10)))
        else $error("decimal remainder out of range");

    // The multiply step belongs to decimal conversion only
    a_mul_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> !r_hex)
        else $error("multiply step during hex conversion");

    // A final byte is only ever held once the sequencer is back at rest
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_state == S_IDLE))
        else $error("last byte held while a conversion is running");
`endif

endmodule
